@@ rtl/npc_pkg.sv @@
`default_nettype none
package npc_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int CFG_W             = 9;
    localparam int CH_W              = 10;
    localparam int IDX_W             = 8;
    localparam int SQ_W              = 20;
    localparam int WGT_W             = 12;
    localparam int DIST_W            = 35;

    localparam logic [CFG_W-1:0] COUNT_RESET = 9'd256;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // redmean weights scaled so the distance stays an exact integer
    localparam int W_RED_BASE  = 1024;
    localparam int W_BLUE_BASE = 1534;
    localparam int W_GREEN_SH  = 11;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic             is_query;
        logic             in_range;
        logic [IDX_W-1:0] entry_index;
        t_rgb             color;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

@@ rtl/npc_if.sv @@
`default_nettype none
interface npc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [npc_pkg::IDX_W-1:0]   entry_index;
    logic [npc_pkg::CH_W-1:0]    red;
    logic [npc_pkg::CH_W-1:0]    green;
    logic [npc_pkg::CH_W-1:0]    blue;

    modport source (output valid, action, entry_index, red, green, blue, input ready);
    modport sink   (input valid, action, entry_index, red, green, blue, output ready);
endinterface

interface npc_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [npc_pkg::IDX_W-1:0]   color_index;

    modport source (output valid, found, color_index, input ready);
    modport sink   (input valid, found, color_index, output ready);
endinterface
`default_nettype wire

@@ rtl/npc_ram.sv @@
`default_nettype none
module npc_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/npc_front.sv @@
`default_nettype none
module npc_front #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    npc_in_if.sink          i_in,
    output logic            o_cmd_valid,
    output npc_pkg::t_cmd   o_cmd,
    input  wire logic       i_cmd_pop
);

    localparam int DEPTH_BITS = $clog2(PALETTE_DEPTH + 1);
    localparam int CMPW       = ((DEPTH_BITS > npc_pkg::IDX_W) ? DEPTH_BITS : npc_pkg::IDX_W) + 1;

    npc_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    npc_pkg::t_cmd w_cmd;
    logic          w_push;
    logic          w_pop;

    // classify the word as it comes in
    always_comb begin
        w_cmd.is_query    = (i_in.action == npc_pkg::ACT_QUERY);
        w_cmd.in_range    = (CMPW'(i_in.entry_index) < CMPW'(PALETTE_DEPTH));
        w_cmd.entry_index = i_in.entry_index;
        w_cmd.color.red   = i_in.red;
        w_cmd.color.green = i_in.green;
        w_cmd.color.blue  = i_in.blue;
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

@@ rtl/npc_dist.sv @@
`default_nettype none
module npc_dist (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic [npc_pkg::IDX_W-1:0]          i_tag,
    input  wire npc_pkg::t_rgb                      i_entry,
    input  wire npc_pkg::t_rgb                      i_query,
    output logic                                    o_valid,
    output logic [npc_pkg::IDX_W-1:0]               o_tag,
    output logic signed [npc_pkg::DIST_W-1:0]       o_dist,
    output logic                                    o_busy
);

    localparam int SQ_W  = npc_pkg::SQ_W;
    localparam int WGT_W = npc_pkg::WGT_W;
    localparam int DW    = npc_pkg::DIST_W;
    localparam int CH_W  = npc_pkg::CH_W;
    localparam int PR_W  = 2 * WGT_W + 8;
    localparam int PG_W  = SQ_W + npc_pkg::W_GREEN_SH;
    localparam int PB_W  = WGT_W + SQ_W + 1;

    logic signed [CH_W:0]       w_dr, w_dg, w_db;
    logic        [CH_W:0]       w_rsum;
    logic signed [2*CH_W+1:0]   w_sq_r, w_sq_g, w_sq_b;

    logic [2:0]                 r_v;
    logic [npc_pkg::IDX_W-1:0]  r_tag_a, r_tag_b, r_tag_c;
    logic [SQ_W-1:0]            r_sq_r, r_sq_g, r_sq_b;
    logic [WGT_W-1:0]           r_wr;
    logic signed [WGT_W-1:0]    r_wb;
    logic [PR_W-1:0]            r_pr;
    logic [PG_W-1:0]            r_pg;
    logic signed [PB_W-1:0]     r_pb;
    logic signed [DW-1:0]       r_dist;

    logic [PR_W-1:0]            w_pr;
    logic signed [PB_W-1:0]     w_pb;
    logic signed [DW-1:0]       w_sum;

    always_comb begin
        w_dr   = $signed({1'b0, i_entry.red})   - $signed({1'b0, i_query.red});
        w_dg   = $signed({1'b0, i_entry.green}) - $signed({1'b0, i_query.green});
        w_db   = $signed({1'b0, i_entry.blue})  - $signed({1'b0, i_query.blue});
        w_rsum = {1'b0, i_entry.red} + {1'b0, i_query.red};
        w_sq_r = w_dr * w_dr;
        w_sq_g = w_dg * w_dg;
        w_sq_b = w_db * w_db;
    end

    always_comb begin
        w_pr  = PR_W'(r_wr) * PR_W'(r_sq_r);
        w_pb  = r_wb * $signed({1'b0, r_sq_b});
        w_sum = $signed(DW'(r_pr)) + $signed(DW'(r_pg))
              + $signed({{(DW-PB_W){r_pb[PB_W-1]}}, r_pb});
    end

    always_ff @(posedge i_clk) begin
        // squares and redmean weights
        r_tag_a <= i_tag;
        r_sq_r  <= w_sq_r[SQ_W-1:0];
        r_sq_g  <= w_sq_g[SQ_W-1:0];
        r_sq_b  <= w_sq_b[SQ_W-1:0];
        r_wr    <= WGT_W'(w_rsum) + WGT_W'(npc_pkg::W_RED_BASE);
        r_wb    <= $signed(WGT_W'(npc_pkg::W_BLUE_BASE)) - $signed(WGT_W'(w_rsum));
        // weighted terms
        r_tag_b <= r_tag_a;
        r_pr    <= w_pr;
        r_pg    <= {r_sq_g, {npc_pkg::W_GREEN_SH{1'b0}}};
        r_pb    <= w_pb;
        // total
        r_tag_c <= r_tag_b;
        r_dist  <= w_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 3'b000;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_tag   = r_tag_c;
    assign o_dist  = r_dist;
    assign o_busy  = |r_v;

endmodule
`default_nettype wire

@@ rtl/npc_back.sv @@
`default_nettype none
module npc_back #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [npc_pkg::CFG_W-1:0]    i_palette_count,
    input  wire logic                         i_cmd_valid,
    input  wire npc_pkg::t_cmd                i_cmd,
    output logic                              o_cmd_pop,
    npc_out_if.source                         o_out
);

    localparam int AW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW0  = $clog2(PALETTE_DEPTH + 1);
    localparam int CW   = (CW0 > npc_pkg::CFG_W) ? CW0 : npc_pkg::CFG_W;
    localparam int DW   = npc_pkg::DIST_W;
    localparam int IW   = npc_pkg::IDX_W;

    npc_pkg::t_state r_state, n_state;

    logic [CW-1:0]         r_addr;
    logic [CW-1:0]         r_last;
    logic                  r_v0;
    logic [IW-1:0]         r_tag0;
    npc_pkg::t_rgb         r_query;
    logic                  r_found;
    logic [DW-2:0]         r_best;
    logic [IW-1:0]         r_best_idx;
    logic                  r_out_valid;
    logic                  r_out_found;
    logic [IW-1:0]         r_out_idx;

    logic [CW-1:0]         w_count;
    logic                  w_pop, w_start, w_ram_we, w_issue, w_result;
    npc_pkg::t_rgb         w_entry;
    logic                  w_d_valid;
    logic [IW-1:0]         w_d_tag;
    logic signed [DW-1:0]  w_d_dist;
    logic                  w_d_busy;
    logic                  w_better;

    // count saturated to the palette depth
    always_comb begin
        if (CW'(i_palette_count) > CW'(PALETTE_DEPTH)) begin
            w_count = CW'(PALETTE_DEPTH);
        end else begin
            w_count = CW'(i_palette_count);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npc_pkg::ST_IDLE: begin
                if (i_cmd_valid && i_cmd.is_query) begin
                    n_state = (w_count == '0) ? npc_pkg::ST_FINISH : npc_pkg::ST_SCAN;
                end
            end
            npc_pkg::ST_SCAN: begin
                if (r_addr == r_last) begin
                    n_state = npc_pkg::ST_DRAIN;
                end
            end
            npc_pkg::ST_DRAIN: begin
                if (!r_v0 && !w_d_busy) begin
                    n_state = npc_pkg::ST_FINISH;
                end
            end
            npc_pkg::ST_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = npc_pkg::ST_IDLE;
                end
            end
            default: n_state = npc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_pop    = 1'b0;
        w_issue  = 1'b0;
        w_result = 1'b0;
        unique case (r_state)
            npc_pkg::ST_IDLE:   w_pop    = i_cmd_valid;
            npc_pkg::ST_SCAN:   w_issue  = 1'b1;
            npc_pkg::ST_DRAIN:  w_issue  = 1'b0;
            npc_pkg::ST_FINISH: w_result = !r_out_valid || o_out.ready;
            default:            w_pop    = 1'b0;
        endcase
        w_start  = w_pop && i_cmd.is_query;
        w_ram_we = w_pop && !i_cmd.is_query && i_cmd.in_range;
    end

    assign o_cmd_pop = w_pop;

    npc_ram #(
        .WIDTH ($bits(npc_pkg::t_rgb)),
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(i_cmd.entry_index)),
        .i_wdata (i_cmd.color),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (w_entry)
    );

    npc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_tag   (r_tag0),
        .i_entry (w_entry),
        .i_query (r_query),
        .o_valid (w_d_valid),
        .o_tag   (w_d_tag),
        .o_dist  (w_d_dist),
        .o_busy  (w_d_busy)
    );

    // a negative weighted sum is never eligible, ties keep the earlier index
    assign w_better = w_d_valid && !w_d_dist[DW-1]
                   && (!r_found || (w_d_dist[DW-2:0] < r_best));

    always_ff @(posedge i_clk) begin
        r_tag0 <= r_addr[IW-1:0];
        if (w_start) begin
            r_query <= i_cmd.color;
            r_last  <= w_count - CW'(1);
        end
        if (w_better) begin
            r_best     <= w_d_dist[DW-2:0];
            r_best_idx <= w_d_tag;
        end
        if (w_result) begin
            r_out_found <= r_found;
            r_out_idx   <= r_found ? r_best_idx : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npc_pkg::ST_IDLE;
            r_addr      <= '0;
            r_v0        <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v0    <= w_issue;
            if (w_start) begin
                r_addr <= '0;
            end else if (w_issue) begin
                r_addr <= r_addr + CW'(1);
            end
            if (w_start) begin
                r_found <= 1'b0;
            end else if (w_better) begin
                r_found <= 1'b1;
            end
            if (w_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.color_index = r_out_idx;

endmodule
`default_nettype wire

@@ rtl/nearest_palette_color_core.sv @@
`default_nettype none
// Nearest palette color search by redmean-weighted distance. Load words
// (action 0) write one palette entry and return nothing; query words
// (action 1) return the lowest index of the entry with the smallest exact
// 512*d^2, skipping entries whose weighted sum is negative, with found=0
// when no entry qualifies. A query scans the first palette_count entries,
// with palette_count limited to PALETTE_DEPTH: the single read port of the
// palette memory delivers one entry per cycle into a three-stage distance
// pipeline, which then drains before the result is handed to the output
// register. A two-word queue in front holds words that arrive while a query
// runs. The palette has no reset: query only entries that have been loaded.
// palette_count resets to 256 and must be written only while the block is
// idle.
module nearest_palette_color_core #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    npc_in_if.sink                           i_in,
    npc_out_if.source                        o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [npc_pkg::CFG_W-1:0]   i_cfg_wdata
);

    logic [npc_pkg::CFG_W-1:0] r_palette_count;
    logic                      w_cmd_valid;
    npc_pkg::t_cmd             w_cmd;
    logic                      w_cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_count <= npc_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_palette_count <= i_cfg_wdata;
        end
    end

    npc_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    npc_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_palette_count (r_palette_count),
        .i_cmd_valid     (w_cmd_valid),
        .i_cmd           (w_cmd),
        .o_cmd_pop       (w_cmd_pop),
        .o_out           (o_out)
    );

endmodule
`default_nettype wire

@@ verif/nearest_palette_color_core_test.sv @@
`default_nettype none
module nearest_palette_color_core_test;
    import npc_pkg::*;

    localparam int DEPTH              = PALETTE_DEPTH_DEF;
    localparam int TARGET_WORDS       = 1650;
    localparam int SETTLE_CYCLES      = 16;
    localparam int RESULT_HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT        = 5000;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] color_index;
    } match_t;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    npc_in_if  in_ch ();
    npc_out_if out_ch ();

    nearest_palette_color_core #(
        .PALETTE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the palette and the search count
    t_rgb             shadow_palette [DEPTH];
    logic [CFG_W-1:0] shadow_count = COUNT_RESET;
    match_t           expected_matches [$];
    int               mismatch_count = 0;

    bit               loaded [DEPTH];
    int               live_count = DEPTH;
    int               words_sent = 0;
    bit               sender_gaps = 1'b1;
    int               hold_requests = 0;
    int               holds_served = 0;
    int               quiet_cycles = 0;

    function automatic match_t nearest_match(t_rgb q);
        match_t m;
        longint best, w, rsum, dr, dg, db;
        int     n;
        m = '0;
        best = 0;
        n = (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
        for (int i = 0; i < n; i++) begin
            rsum = longint'(shadow_palette[i].red) + longint'(q.red);
            dr   = longint'(shadow_palette[i].red) - longint'(q.red);
            dg   = longint'(shadow_palette[i].green) - longint'(q.green);
            db   = longint'(shadow_palette[i].blue) - longint'(q.blue);
            w = (W_RED_BASE + rsum) * dr * dr + (longint'(1) << W_GREEN_SH) * dg * dg
                + (W_BLUE_BASE - rsum) * db * db;
            // a negative weighted sum never wins, ties keep the lower index
            if (w >= 0 && (!m.found || w < best)) begin
                m.found = 1'b1;
                m.color_index = IDX_W'(i);
                best = w;
            end
        end
        return m;
    endfunction

    function automatic int idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(0, 9))
            0: return CH_W'(0);
            1: return CH_W'(1000);
            2: return CH_W'($urandom_range(1001, 1023));
            default: return CH_W'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic t_rgb rand_color();
        t_rgb c;
        c.red   = rand_channel();
        c.green = rand_channel();
        c.blue  = rand_channel();
        return c;
    endfunction

    function automatic t_rgb pick_query_color();
        t_rgb c;
        c = rand_color();
        // land on or next to a searched entry now and then
        if (live_count > 0 && $urandom_range(0, 3) == 0) begin
            c = shadow_palette[$urandom_range(0, live_count - 1)];
            if ($urandom_range(0, 1) == 1)
                c.green = c.green ^ CH_W'($urandom_range(0, 7));
        end
        return c;
    endfunction

    task automatic send_word(logic act, logic [IDX_W-1:0] idx, t_rgb c);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.entry_index <= idx;
        in_ch.red         <= c.red;
        in_ch.green       <= c.green;
        in_ch.blue        <= c.blue;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        words_sent++;
        if (act == ACT_LOAD) begin
            shadow_palette[idx] = c;
            loaded[idx] = 1'b1;
        end else begin
            expected_matches.push_back(nearest_match(c));
        end
        gap = sender_gaps ? idle_length() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        // trailing loads may still sit in the input queue
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_count = CFG_W'(value);
        live_count = (value > DEPTH) ? DEPTH : int'(value);
    endtask

    // every searched entry must hold a written color before a query
    task automatic fill_palette();
        for (int i = 0; i < live_count; i++)
            if (!loaded[i]) send_word(ACT_LOAD, IDX_W'(i), rand_color());
    endtask

    task automatic issue_query();
        send_word(ACT_QUERY, IDX_W'($urandom), pick_query_color());
    endtask

    task automatic random_load();
        logic [IDX_W-1:0] slot;
        t_rgb             c;
        if (live_count > 0 && $urandom_range(0, 4) < 3)
            slot = IDX_W'($urandom_range(0, live_count - 1));
        else
            slot = IDX_W'($urandom_range(0, DEPTH - 1));
        c = rand_color();
        // duplicates give ties
        if (live_count > 0 && $urandom_range(0, 4) == 0)
            c = shadow_palette[$urandom_range(0, live_count - 1)];
        send_word(ACT_LOAD, slot, c);
    endtask

    task automatic test_directed();
        write_count(1);
        send_word(ACT_LOAD, 8'd0, '{10'd1023, 10'd0, 10'd0});
        // red sum above the blue base with a large blue step: weight is negative
        send_word(ACT_QUERY, 8'd255, '{10'd1023, 10'd0, 10'd1023});
        send_word(ACT_QUERY, 8'd0, '{10'd0, 10'd0, 10'd0});
        send_word(ACT_LOAD, 8'd1, '{10'd1023, 10'd1023, 10'd1023});
        send_word(ACT_LOAD, 8'd2, '{10'd1023, 10'd0, 10'd0});
        send_word(ACT_LOAD, 8'd255, '{10'd0, 10'd0, 10'd0});
        send_word(ACT_LOAD, 8'd170, '{10'd682, 10'd341, 10'd1000});
        send_word(ACT_LOAD, 8'd85, '{10'd341, 10'd682, 10'd512});
        write_count(0);
        send_word(ACT_QUERY, 8'd85, '{10'd500, 10'd500, 10'd500});
        send_word(ACT_QUERY, 8'd170, '{10'd1023, 10'd1023, 10'd1023});
        write_count(3);
        send_word(ACT_QUERY, 8'd0, '{10'd1000, 10'd0, 10'd0});
        send_word(ACT_QUERY, 8'd0, '{10'd1023, 10'd1023, 10'd1023});
        send_word(ACT_QUERY, 8'd0, '{10'd1023, 10'd0, 10'd1023});
        send_word(ACT_QUERY, 8'd0, '{10'd500, 10'd500, 10'd500});
        send_word(ACT_QUERY, 8'd0, '{10'd0, 10'd1023, 10'd0});
        send_word(ACT_QUERY, 8'd0, '{10'd1000, 10'd1000, 10'd1000});
    endtask

    task automatic test_full_palette();
        write_count(511);
        fill_palette();
        repeat (12) issue_query();
        write_count(COUNT_RESET);
        repeat (8) issue_query();
        write_count(255);
        repeat (8) issue_query();
        write_count(300);
        repeat (4) issue_query();
    endtask

    task automatic test_backpressure();
        write_count(6);
        fill_palette();
        sender_gaps = 1'b0;
        hold_requests++;
        repeat (30) begin
            if ($urandom_range(0, 4) == 0) random_load();
            else issue_query();
        end
        sender_gaps = 1'b1;
        wait_idle();
    endtask

    task automatic test_random_phases();
        int unsigned count_choice;
        while (words_sent < TARGET_WORDS) begin
            case ($urandom_range(0, 19))
                0:       count_choice = 0;
                1:       count_choice = $urandom_range(256, 511);
                2:       count_choice = $urandom_range(255, 256);
                3, 4:    count_choice = $urandom_range(17, 64);
                default: count_choice = $urandom_range(1, 16);
            endcase
            write_count(count_choice);
            fill_palette();
            sender_gaps = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(20, 60)) begin
                if ($urandom_range(0, 9) < 4) random_load();
                else issue_query();
            end
        end
        sender_gaps = 1'b1;
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_requests != holds_served) begin
                holds_served++;
                out_ch.ready <= 1'b0;
                repeat (RESULT_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                int stall;
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                stall = idle_length();
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        match_t want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_matches.size() == 0) begin
                $error("result word with no query waiting: found=%0b color_index=%0d",
                       out_ch.found, out_ch.color_index);
                mismatch_count++;
            end else begin
                want = expected_matches.pop_front();
                if (out_ch.found !== want.found) begin
                    $error("found: expected %0b, actual %0b", want.found, out_ch.found);
                    mismatch_count++;
                end
                if (out_ch.color_index !== want.color_index) begin
                    $error("color_index: expected %0d, actual %0d",
                           want.color_index, out_ch.color_index);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || i_cfg_we === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_LOAD;
        in_ch.entry_index <= '0;
        in_ch.red         <= '0;
        in_ch.green       <= '0;
        in_ch.blue        <= '0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_rst_n           <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_palette();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (64) @(posedge i_clk);
        if (mismatch_count == 0 && expected_matches.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/npc_pkg.sv
rtl/npc_if.sv
rtl/npc_ram.sv
rtl/npc_front.sv
rtl/npc_dist.sv
rtl/npc_back.sv
rtl/nearest_palette_color_core.sv
verif/nearest_palette_color_core_test.sv
